/* rtl/complementary_tilt_filter_assert.svh */
// Assertion macros for the complementary tilt filter checker.
// No dependencies.
`ifndef COMPLEMENTARY_TILT_FILTER_ASSERT_SVH
`define COMPLEMENTARY_TILT_FILTER_ASSERT_SVH

// Property checked only while out of reset.
`define CTF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every edge, reset included.
`define CTF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/ctf_pkg.sv */
// Package for the complementary tilt filter: widths, codes, CORDIC table, helpers.
// No dependencies.
`timescale 1ns / 1ps
package ctf_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int TAB_DEPTH    = 24;
    localparam int TAB_W        = $clog2(TAB_DEPTH);
    localparam int CW           = 27;   // CORDIC datapath width
    localparam int MUL_A_W      = 17;
    localparam int MUL_B_W      = 34;
    localparam int PROD_W       = MUL_A_W + MUL_B_W;
    localparam int WIDE_W       = 53;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 1'b1;

    localparam logic [15:0] ALPHA_RST  = 16'd29789;
    localparam logic [15:0] PERIOD_RST = 16'd328;

    localparam logic signed [CW-1:0] ANG_180   = 27'sd11796480;
    localparam logic signed [31:0]   ANG_90_Q8 = 32'sd23040;

    typedef enum logic [2:0] {
        S_IDLE, S_CORDIC, S_GYRO_MUL, S_GYRO_ACC,
        S_LP_MUL, S_LP_ACC, S_HP_MUL, S_HP_ACC
    } t_state;

    typedef struct packed {
        logic               start;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } t_cordic_req;

    typedef struct packed {
        logic               done;
        logic signed [31:0] angle;
    } t_cordic_rsp;

    function automatic logic signed [CW-1:0] atan_lut(input logic [TAB_W-1:0] i);
        logic signed [CW-1:0] v;
        v = '0;
        case (i)
            5'd0:  v = 27'sd2949120;
            5'd1:  v = 27'sd1740967;
            5'd2:  v = 27'sd919879;
            5'd3:  v = 27'sd466945;
            5'd4:  v = 27'sd234379;
            5'd5:  v = 27'sd117304;
            5'd6:  v = 27'sd58666;
            5'd7:  v = 27'sd29335;
            5'd8:  v = 27'sd14668;
            5'd9:  v = 27'sd7334;
            5'd10: v = 27'sd3667;
            5'd11: v = 27'sd1833;
            5'd12: v = 27'sd917;
            5'd13: v = 27'sd458;
            5'd14: v = 27'sd229;
            5'd15: v = 27'sd115;
            5'd16: v = 27'sd57;
            5'd17: v = 27'sd29;
            5'd18: v = 27'sd14;
            5'd19: v = 27'sd7;
            5'd20: v = 27'sd4;
            5'd21: v = 27'sd2;
            5'd22: v = 27'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [WIDE_W-1:0] v);
        logic signed [31:0] r;
        if (v > WIDE_W'(signed'(32'sh7fffffff)))
            r = 32'sh7fffffff;
        else if (v < WIDE_W'(signed'(32'sh80000000)))
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

/* rtl/ctf_if.sv */
// Channel interfaces for the tilt filter: sample input and result output.
// Depends on nothing.
`timescale 1ns / 1ps
interface ctf_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] gyro_rate;
    modport source (output valid, accel_y, accel_z, gyro_rate, input ready);
    modport sink   (input valid, accel_y, accel_z, gyro_rate, output ready);
endinterface

interface ctf_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] accel_angle;
    logic signed [31:0] gyro_angle;
    logic signed [31:0] fused_angle;
    modport source (output valid, accel_angle, gyro_angle, fused_angle, input ready);
    modport sink   (input valid, accel_angle, gyro_angle, fused_angle, output ready);
endinterface

/* rtl/ctf_cordic.sv */
// Iterative vectoring CORDIC: atan2(y, z) minus 90 degrees, 1/256 degree out.
// Depends on ctf_pkg.
`timescale 1ns / 1ps
module ctf_cordic import ctf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cordic_req i_req,
    output t_cordic_rsp o_rsp
);
    logic signed [CW-1:0] r_x, r_w, r_ang;
    logic signed [CW-1:0] n_x, n_w, n_ang;
    logic [TAB_W-1:0]     r_cnt;
    logic                 r_busy, r_done, r_zero;
    logic signed [CW-1:0] x0, w0, rnd;

    always_comb begin
        x0 = CW'(i_req.z) <<< 8;
        w0 = CW'(i_req.y) <<< 8;
        n_ang = '0;
        if (i_req.z < 0) begin
            x0 = -x0;
            w0 = -w0;
            n_ang = (i_req.y >= 0) ? ANG_180 : -ANG_180;
        end
        n_x = x0;
        n_w = w0;
        if (r_busy) begin
            if (r_w > 0) begin
                n_x   = r_x + (r_w >>> r_cnt);
                n_w   = r_w - (r_x >>> r_cnt);
                n_ang = r_ang + atan_lut(r_cnt);
            end else begin
                n_x   = r_x - (r_w >>> r_cnt);
                n_w   = r_w + (r_x >>> r_cnt);
                n_ang = r_ang - atan_lut(r_cnt);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == TAB_W'(CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end else if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy || i_req.start) begin
            r_x   <= n_x;
            r_w   <= n_w;
            r_ang <= n_ang;
        end
        if (!r_busy && i_req.start)
            r_zero <= (i_req.y == 0) && (i_req.z == 0);
    end

    assign rnd = (r_ang + CW'(128)) >>> 8;
    assign o_rsp.done  = r_done;
    assign o_rsp.angle = r_zero ? -ANG_90_Q8 : (32'(rnd) - ANG_90_Q8);
endmodule

/* rtl/ctf_mul.sv */
// Shared signed multiplier with registered product for the gyro and filter steps.
// Depends on ctf_pkg.
`timescale 1ns / 1ps
module ctf_mul import ctf_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic signed [MUL_A_W-1:0] i_a,
    input  logic signed [MUL_B_W-1:0] i_b,
    output logic signed [PROD_W-1:0]  o_prod
);
    logic signed [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (i_en)
            r_prod <= PROD_W'(i_a) * PROD_W'(i_b);
    end

    assign o_prod = r_prod;
endmodule

/* rtl/complementary_tilt_filter.sv */
// Complementary tilt filter: one result per sample, 1/256 degree angles.
// Path: the 16 CORDIC steps, then multiply and accumulate for gyro, low-pass and high-pass, then the output register.
// One sample in work at a time: the CORDIC loop and the shared multiplier take no new sample before the last is done.
// Not ready while a sample is in work or a result waits for the output register.
// Sync active-low reset clears filter state, config to defaults, no result pending.
`timescale 1ns / 1ps
module complementary_tilt_filter import ctf_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    ctf_in_if.sink                i_sample,
    ctf_out_if.source             o_result,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);
    t_state r_state, n_state;
    logic [15:0] r_alpha, r_period;
    logic signed [31:0] r_gi, r_lp, r_hp_in, r_hp, r_acc;
    logic signed [15:0] r_gr;
    logic r_pend;  // finished result not yet loaded to output
    logic r_ovalid;
    logic signed [31:0] r_o_acc, r_o_gyro, r_o_fused;

    t_cordic_req creq;
    t_cordic_rsp crsp;
    logic mul_en;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod;
    logic signed [WIDE_W-1:0]  p_wide;
    logic in_acc, load_out;

    ctf_cordic u_cordic (.i_clk, .i_rst_n, .i_req(creq), .o_rsp(crsp));
    ctf_mul u_mul (.i_clk, .i_en(mul_en), .i_a(mul_a), .i_b(mul_b), .o_prod(prod));

    assign p_wide = WIDE_W'(prod);
    assign in_acc = i_sample.valid && i_sample.ready;
    assign load_out = r_pend && (!r_ovalid || o_result.ready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:     if (in_acc) n_state = S_CORDIC;
            S_CORDIC:   if (crsp.done) n_state = S_GYRO_MUL;
            S_GYRO_MUL: n_state = S_GYRO_ACC;
            S_GYRO_ACC: n_state = S_LP_MUL;
            S_LP_MUL:   n_state = S_LP_ACC;
            S_LP_ACC:   n_state = S_HP_MUL;
            S_HP_MUL:   n_state = S_HP_ACC;
            S_HP_ACC:   n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        i_sample.ready = (r_state == S_IDLE) && !r_pend;
        creq.start = in_acc;
        creq.y     = i_sample.accel_y;
        creq.z     = i_sample.accel_z;
        mul_en = 1'b0;
        mul_a  = MUL_A_W'({1'b0, r_alpha});
        mul_b  = '0;
        unique case (r_state)
            S_GYRO_MUL: begin
                mul_en = 1'b1;
                mul_a  = MUL_A_W'({1'b0, r_period});
                mul_b  = MUL_B_W'(r_gr);
            end
            S_LP_MUL: begin
                mul_en = 1'b1;
                mul_b  = MUL_B_W'(r_acc) - MUL_B_W'(r_lp);
            end
            S_HP_MUL: begin
                mul_en = 1'b1;
                mul_b  = MUL_B_W'(r_hp) + MUL_B_W'(r_gi) - MUL_B_W'(r_hp_in);
            end
            default: mul_en = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_alpha  <= ALPHA_RST;
            r_period <= PERIOD_RST;
            r_gi     <= '0;
            r_lp     <= '0;
            r_hp_in  <= '0;
            r_hp     <= '0;
            r_pend   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_ALPHA:  r_alpha  <= i_cfg_data;
                    CFG_PERIOD: r_period <= i_cfg_data;
                    default:    r_alpha  <= r_alpha;
                endcase
            end
            if (r_state == S_GYRO_ACC)
                r_gi <= sat32(WIDE_W'(r_gi) + ((p_wide + WIDE_W'(2048)) >>> 12));
            if (r_state == S_LP_ACC)
                r_lp <= sat32(WIDE_W'(r_lp) + ((p_wide + WIDE_W'(16384)) >>> 15));
            if (r_state == S_HP_ACC) begin
                r_hp    <= sat32((p_wide + WIDE_W'(16384)) >>> 15);
                r_hp_in <= r_gi;
                r_pend  <= 1'b1;
            end else if (load_out) begin
                r_pend <= 1'b0;
            end
            if (load_out)
                r_ovalid <= 1'b1;
            else if (o_result.ready)
                r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc)
            r_gr <= i_sample.gyro_rate;
        if (crsp.done)
            r_acc <= crsp.angle;
        if (load_out) begin
            r_o_acc   <= r_acc;
            r_o_gyro  <= r_gi;
            r_o_fused <= sat32(WIDE_W'(r_lp) + WIDE_W'(r_hp));
        end
    end

    assign o_result.valid       = r_ovalid;
    assign o_result.accel_angle = r_o_acc;
    assign o_result.gyro_angle  = r_o_gyro;
    assign o_result.fused_angle = r_o_fused;
endmodule

/* rtl/ctf_checker.sv */
// Port-level checker for the complementary tilt filter, bound to the top level.
// Depends on complementary_tilt_filter_assert.svh.
`timescale 1ns / 1ps
`include "complementary_tilt_filter_assert.svh"
module ctf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_out_fused
);
    `CTF_ASSERT_ALWAYS(a_rst_clear, i_clk, !$past(i_rst_n) |-> !i_out_valid, "result after reset")
    `CTF_ASSERT(a_busy, i_clk, i_rst_n, (i_in_valid && i_in_ready) |=> !i_in_ready, "ready while busy")
    `CTF_ASSERT(a_hold, i_clk, i_rst_n, (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_fused)), "stalled result changed")
endmodule

bind complementary_tilt_filter ctf_checker u_ctf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_sample.valid),
    .i_in_ready  (i_sample.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_out_fused (o_result.fused_angle)
);
